/* hdl/hwpl_pkg.sv */
// Shared types for the Huffman tree weighted path length unit.
// Holds the controller state encoding and the command and status bundles.
package hwpl_pkg;

  typedef enum logic [5:0] {
    ST_LOAD  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_DRAIN = 6'b000100,
    ST_NEW   = 6'b001000,
    ST_WA    = 6'b010000,
    ST_WB    = 6'b100000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // an input transaction is taken this cycle
    logic scan_rd;   // issue one node table read
    logic wr_new;    // write the merged node
    logic wr_a;      // mark the smaller child as parented
    logic wr_b;      // mark the second child as parented
    logic out_load;  // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic few_leaves;  // fewer than two leaves will be stored
    logic last_rd;     // the read issued now is the last of the scan
    logic build_done;  // the merge being finished is the final one
    logic out_free;    // the output register can take a result
  } sts_t;

endpackage

/* hdl/hwpl_in_if.sv */
// Input channel of the Huffman tree weighted path length unit.
// Carries one leaf weight and its end-of-set mark; no dependencies.
interface hwpl_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] weight;
  logic        last;

  modport source(output valid, output weight, output last, input ready);
  modport sink(input valid, input weight, input last, output ready);
endinterface

/* hdl/hwpl_out_if.sv */
// Result channel of the Huffman tree weighted path length unit.
// Carries the path length sum and the overflow flag; no dependencies.
interface hwpl_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] wpl;
  logic        too_many;

  modport source(output valid, output wpl, output too_many, input ready);
  modport sink(input valid, input wpl, input too_many, output ready);
endinterface

/* hdl/hwpl_ram.sv */
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module hwpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/hwpl_ctrl.sv */
// Controller state machine for the Huffman tree weighted path length unit.
// Depends on hwpl_pkg for the state, command and status types.
module hwpl_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last,
  input  hwpl_pkg::sts_t sts,
  output logic          in_ready,
  output hwpl_pkg::cmd_t cmd
);

  hwpl_pkg::state_t state_r, state_nxt;
  logic out_pend_r, out_pend_nxt;

  always_comb begin
    state_nxt    = state_r;
    out_pend_nxt = out_pend_r;
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state_r)
      hwpl_pkg::ST_LOAD: begin
        // While a finished result waits for its slot, hold new input.
        if (out_pend_r) begin
          if (sts.out_free) begin
            cmd.out_load = 1'b1;
            out_pend_nxt = 1'b0;
          end
        end else begin
          in_ready = 1'b1;
          if (in_valid) begin
            cmd.load = 1'b1;
            if (in_last) begin
              if (sts.few_leaves) begin
                out_pend_nxt = 1'b1;
              end else begin
                state_nxt = hwpl_pkg::ST_SCAN;
              end
            end
          end
        end
      end
      hwpl_pkg::ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.last_rd) begin
          state_nxt = hwpl_pkg::ST_DRAIN;
        end
      end
      hwpl_pkg::ST_DRAIN: state_nxt = hwpl_pkg::ST_NEW;
      hwpl_pkg::ST_NEW: begin
        cmd.wr_new = 1'b1;
        state_nxt  = hwpl_pkg::ST_WA;
      end
      hwpl_pkg::ST_WA: begin
        cmd.wr_a  = 1'b1;
        state_nxt = hwpl_pkg::ST_WB;
      end
      hwpl_pkg::ST_WB: begin
        cmd.wr_b = 1'b1;
        if (sts.build_done) begin
          state_nxt    = hwpl_pkg::ST_LOAD;
          out_pend_nxt = 1'b1;
        end else begin
          state_nxt = hwpl_pkg::ST_SCAN;
        end
      end
      default: state_nxt = hwpl_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= hwpl_pkg::ST_LOAD;
      out_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      out_pend_r <= out_pend_nxt;
    end
  end

endmodule

/* hdl/hwpl_dp.sv */
// Datapath of the Huffman tree weighted path length unit: node table,
// scan trackers, merge accumulator and output register. Uses hwpl_pkg, hwpl_ram.
module hwpl_dp #(
  parameter int MAX_LEAVES  = 256,
  parameter int WEIGHT_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  hwpl_pkg::cmd_t cmd,
  input  logic [15:0]    in_weight,
  input  logic           in_last,
  input  logic           out_ready,
  output hwpl_pkg::sts_t sts,
  output logic           out_valid,
  output logic [31:0]    out_wpl,
  output logic           out_too_many
);

  localparam int NODES = 2 * MAX_LEAVES - 1;
  localparam int AW    = $clog2(NODES);
  localparam int KW    = $clog2(NODES + 1);
  localparam int CW    = $clog2(MAX_LEAVES + 1);
  localparam int KB    = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
  localparam int NW    = KB + $clog2(MAX_LEAVES);

  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic          rd_vld_r;
  logic [AW-1:0] rd_idx_r;
  logic          have_a_r, have_b_r, have_a_nxt, have_b_nxt;
  logic [AW-1:0] a_idx_r, b_idx_r, a_idx_nxt, b_idx_nxt;
  logic [NW-1:0] a_w_r, b_w_r, a_w_nxt, b_w_nxt;
  logic [31:0]   acc_r, acc_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_wpl_r;
  logic          out_tm_r;

  logic          we;
  logic [AW-1:0] waddr;
  logic [NW:0]   wdata, rdata;
  logic [NW-1:0] rd_w, sum_w, leaf_w;
  logic          rd_hp, room, scan_clr;
  logic [32:0]   acc_sum;

  hwpl_ram #(.WIDTH(NW + 1), .DEPTH(NODES)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(i_r),
    .rdata(rdata)
  );

  assign rd_hp   = rdata[NW];
  assign rd_w    = rdata[NW-1:0];
  assign sum_w   = a_w_r + b_w_r;
  assign leaf_w  = NW'(in_weight[KB-1:0]);
  assign room    = (count_r < CW'(MAX_LEAVES));
  assign acc_sum = {1'b0, acc_r} + 33'(sum_w);
  assign scan_clr = (cmd.load && in_last) || cmd.wr_b;

  assign sts.few_leaves = (count_r == '0);
  assign sts.last_rd    = (KW'(i_r) == k_r - KW'(1));
  assign sts.build_done = ((k_r + KW'(1)) == ((KW'(count_r) << 1) - KW'(1)));
  assign sts.out_free   = !out_valid_r || out_ready;

  // Node table write port.
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    if (cmd.load && room) begin
      we    = 1'b1;
      waddr = AW'(count_r);
      wdata = {1'b0, leaf_w};
    end else if (cmd.wr_new) begin
      we    = 1'b1;
      waddr = k_r[AW-1:0];
      wdata = {1'b0, sum_w};
    end else if (cmd.wr_a) begin
      we    = 1'b1;
      waddr = a_idx_r;
      wdata = {1'b1, a_w_r};
    end else if (cmd.wr_b) begin
      we    = 1'b1;
      waddr = b_idx_r;
      wdata = {1'b1, b_w_r};
    end
  end

  always_comb begin
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    have_a_nxt    = have_a_r;
    have_b_nxt    = have_b_r;
    a_idx_nxt     = a_idx_r;
    b_idx_nxt     = b_idx_r;
    a_w_nxt       = a_w_r;
    b_w_nxt       = b_w_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmd.load) begin
      if (room) begin
        count_nxt = count_r + CW'(1);
        k_nxt     = KW'(count_r) + KW'(1);
      end else begin
        ovf_nxt = 1'b1;
        k_nxt   = KW'(count_r);
      end
    end
    if (cmd.scan_rd) begin
      i_nxt = i_r + AW'(1);
    end
    // Running two-smallest search; strict less-than keeps the earlier index.
    if (rd_vld_r && !rd_hp) begin
      if (!have_a_r) begin
        have_a_nxt = 1'b1;
        a_idx_nxt  = rd_idx_r;
        a_w_nxt    = rd_w;
      end else if (!have_b_r || rd_w < a_w_r) begin
        have_b_nxt = 1'b1;
        if (rd_w < a_w_r) begin
          b_idx_nxt = a_idx_r;
          b_w_nxt   = a_w_r;
          a_idx_nxt = rd_idx_r;
          a_w_nxt   = rd_w;
        end else begin
          b_idx_nxt = rd_idx_r;
          b_w_nxt   = rd_w;
        end
      end else if (rd_w < b_w_r) begin
        b_idx_nxt = rd_idx_r;
        b_w_nxt   = rd_w;
      end
    end
    // Each merged node adds its weight once, saturating at 32 bits.
    if (cmd.wr_new) begin
      acc_nxt = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
    end
    if (cmd.wr_b) begin
      k_nxt = k_r + KW'(1);
    end
    if (scan_clr) begin
      i_nxt      = '0;
      have_a_nxt = 1'b0;
      have_b_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      count_nxt     = '0;
      ovf_nxt       = 1'b0;
      acc_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      k_r         <= '0;
      i_r         <= '0;
      rd_vld_r    <= 1'b0;
      have_a_r    <= 1'b0;
      have_b_r    <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      k_r         <= k_nxt;
      i_r         <= i_nxt;
      rd_vld_r    <= cmd.scan_rd;
      have_a_r    <= have_a_nxt;
      have_b_r    <= have_b_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= i_r;
    a_idx_r  <= a_idx_nxt;
    b_idx_r  <= b_idx_nxt;
    a_w_r    <= a_w_nxt;
    b_w_r    <= b_w_nxt;
    if (cmd.out_load) begin
      out_wpl_r <= acc_r;
      out_tm_r  <= ovf_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_wpl      = out_wpl_r;
  assign out_too_many = out_tm_r;

endmodule

/* hdl/huffman_tree_wpl_unit.sv */
// Huffman tree weighted path length unit, top level.
// Leaves load at one transaction per cycle while input is not held off. After
// the last leaf of n stored leaves, the n-1 merges k = n .. 2n-2 each scan the
// node table through its single read port; then the result is registered out.
// Reset (rst_n low, synchronous) empties the leaf set and the output register.
module huffman_tree_wpl_unit #(
  parameter int MAX_LEAVES  = 256,
  parameter int WEIGHT_BITS = 16
) (
  input logic         clk,
  input logic         rst_n,
  hwpl_in_if.sink     in_ch,
  hwpl_out_if.source  out_ch
);

  // The controller sequences loading, scanning and merging; the datapath
  // owns the node table, in which each entry holds a weight and a flag
  // telling whether the node already has a parent. Entries are written
  // before the scan reaches them in every set, so no clearing is needed.
  hwpl_pkg::cmd_t cmd;
  hwpl_pkg::sts_t sts;

  hwpl_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_last (in_ch.last),
    .sts     (sts),
    .in_ready(in_ch.ready),
    .cmd     (cmd)
  );

  // The path length sum is accumulated as the sum of all merged node
  // weights, which equals each leaf's weight times its depth.
  hwpl_dp #(
    .MAX_LEAVES (MAX_LEAVES),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_weight   (in_ch.weight),
    .in_last     (in_ch.last),
    .out_ready   (out_ch.ready),
    .sts         (sts),
    .out_valid   (out_ch.valid),
    .out_wpl     (out_ch.wpl),
    .out_too_many(out_ch.too_many)
  );

endmodule

/* hdl/hwpl_chk.sv */
// Port-level checker for the Huffman tree weighted path length unit,
// bound to huffman_tree_wpl_unit. No package dependencies.
module hwpl_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_wpl,
  input logic        out_too_many
);

  // A transaction that ends a set makes the unit busy in the next cycle.
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input accepted right after the last leaf");

  // A new result appears only right after input was held off.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a build");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_wpl) && $stable(out_too_many))
    else $error("result changed while stalled");

endmodule

bind huffman_tree_wpl_unit hwpl_chk u_hwpl_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_last     (in_ch.last),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_wpl     (out_ch.wpl),
  .out_too_many(out_ch.too_many)
);

/* test/tb_huffman_tree_wpl_unit.sv */
// Self-checking testbench for the Huffman tree weighted path length unit.
// Depends on hdl/hwpl_pkg.sv, hdl/hwpl_in_if.sv, hdl/hwpl_out_if.sv and the top level.
module tb_huffman_tree_wpl_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEAF_CAP = 256;
  localparam int NODE_CAP = 2 * LEAF_CAP - 1;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [31:0] wpl;
    logic        too_many;
  } wpl_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hwpl_in_if  in_ch();
  hwpl_out_if out_ch();

  huffman_tree_wpl_unit #(.MAX_LEAVES(LEAF_CAP), .WEIGHT_BITS(16)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // Idle percentages for each side; the receiver also honors a long hold-off.
  int unsigned in_idle_pct = 0;
  int unsigned out_idle_pct = 0;
  int unsigned hold_left = 0;
  int unsigned errors = 0;
  longint cycles = 0;

  // Predictor state: the leaves of the set being loaded and the overflow flag.
  logic [15:0] set_leaves[$];
  logic set_overflow = 1'b0;
  wpl_result_t pending_wpl[$];

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.weight = '0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
  end

  // The run is cut off if it goes on far longer than the slowest correct run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Builds the Huffman tree exactly as the block does: each new node takes
  // the next index, and its children are the two smallest unparented nodes,
  // found by an index-order scan with strict less-than so that ties go to
  // the lower index. The sum of weight times depth saturates at 32 bits.
  function automatic logic [31:0] tree_path_length(input logic [15:0] leaves[$]);
    logic [23:0] nw[NODE_CAP];
    int          np[NODE_CAP];
    bit          parented[NODE_CAP];
    int n, a, b, p, depth;
    bit have_a, have_b;
    longint sum;
    n = leaves.size();
    sum = 0;
    if (n < 2) return 32'd0;
    for (int i = 0; i < NODE_CAP; i++) begin
      parented[i] = 1'b0;
      np[i] = 0;
      nw[i] = (i < n) ? 24'(leaves[i]) : 24'd0;
    end
    for (int k = n; k < 2 * n - 1; k++) begin
      have_a = 0;
      have_b = 0;
      a = 0;
      b = 0;
      for (int i = 0; i < k; i++) begin
        if (parented[i]) continue;
        if (!have_a) begin
          a = i;
          have_a = 1;
        end else if (!have_b) begin
          if (nw[i] < nw[a]) begin
            b = a;
            a = i;
          end else begin
            b = i;
          end
          have_b = 1;
        end else if (nw[i] < nw[a]) begin
          b = a;
          a = i;
        end else if (nw[i] < nw[b]) begin
          b = i;
        end
      end
      nw[k] = nw[a] + nw[b];
      parented[k] = 1'b0;
      np[a] = k;
      np[b] = k;
      parented[a] = 1'b1;
      parented[b] = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      depth = 0;
      p = i;
      while (parented[p]) begin
        depth++;
        p = np[p];
      end
      sum += longint'(nw[i]) * depth;
    end
    return (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  // Offers one leaf, with random idle cycles first, and updates the predicted
  // set when the transaction is taken. Returns at the next falling edge.
  task automatic send_leaf(input logic [15:0] w, input logic is_last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.weight <= w;
    in_ch.last <= is_last;
    do @(posedge clk); while (!in_ch.ready);
    if (set_leaves.size() < LEAF_CAP) set_leaves.push_back(w);
    else set_overflow = 1'b1;
    if (is_last) begin
      pending_wpl.push_back('{wpl: tree_path_length(set_leaves), too_many: set_overflow});
      set_leaves.delete();
      set_overflow = 1'b0;
    end
    @(negedge clk);
  endtask

  // A random weight: full range half the time, otherwise small so that ties happen.
  function automatic logic [15:0] rand_weight();
    case ($urandom_range(3))
      0: return 16'($urandom_range(7));
      1: return 16'($urandom_range(255));
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic send_set(input int size, input int mode);
    for (int i = 0; i < size; i++) begin
      case (mode)
        1: send_leaf(16'hFFFF, i == size - 1);
        2: send_leaf(16'd0, i == size - 1);
        3: send_leaf(16'd5, i == size - 1);
        default: send_leaf(rand_weight(), i == size - 1);
      endcase
    end
  endtask

  // Receiver: ready changes at the falling edge, stalled at random or during
  // a hold-off that counts down here.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Result checker: every accepted result is matched with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_wpl.size() == 0) begin
        $display("%0t: unexpected result wpl=%0d too_many=%0b", $time,
                 out_ch.wpl, out_ch.too_many);
        errors++;
      end else begin
        wpl_result_t exp_r;
        exp_r = pending_wpl.pop_front();
        if (out_ch.wpl !== exp_r.wpl) begin
          $display("%0t: wpl expected %0d actual %0d", $time, exp_r.wpl, out_ch.wpl);
          errors++;
        end
        if (out_ch.too_many !== exp_r.too_many) begin
          $display("%0t: too_many expected %0b actual %0b", $time,
                   exp_r.too_many, out_ch.too_many);
          errors++;
        end
      end
    end
  end

  // Extremes, single leaves, two leaves, ties and all-zero sets.
  task automatic test_directed();
    send_leaf(16'd0, 1'b1);
    send_leaf(16'hFFFF, 1'b1);
    send_leaf(16'd1, 1'b0);
    send_leaf(16'hFFFF, 1'b1);
    send_set(4, 3);
    send_set(5, 2);
    send_set(6, 1);
    send_leaf(16'd3, 1'b0);
    send_leaf(16'd1, 1'b0);
    send_leaf(16'd1, 1'b0);
    send_leaf(16'd2, 1'b1);
  endtask

  // A full set, then an overflowing one whose last leaf is itself dropped.
  task automatic test_capacity();
    send_set(LEAF_CAP, 0);
    send_set(LEAF_CAP + 4, 0);
  endtask

  // Random small sets until about the requested number of leaves is sent.
  task automatic test_random_sets(input int leaves, input int unsigned ip,
                                  input int unsigned op);
    int sent;
    in_idle_pct = ip;
    out_idle_pct = op;
    sent = 0;
    while (sent < leaves) begin
      int sz;
      sz = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 12);
      send_set(sz, 0);
      sent += sz;
    end
  endtask

  // The receiver holds off for a long stretch while sets keep coming, so the
  // output register stays full and the block must stall its input.
  task automatic test_backpressure();
    in_idle_pct = 0;
    out_idle_pct = 0;
    @(posedge clk);
    hold_left = 3000;
    for (int i = 0; i < 20; i++) send_set(3, 0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_capacity();
    test_random_sets(380, 13, 84);
    test_random_sets(380, 84, 13);
    test_random_sets(380, 0, 0);
    test_backpressure();
    in_ch.valid <= 1'b0;
    while (pending_wpl.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
